// ===== rtl/assert_macros.svh =====
// concurrent assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/aswt_pkg.sv =====
package aswt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int DEFAULT_PRICE_BITS  = 32;

    // port field widths
    localparam int PRICE_W = 32;
    localparam int KIND_W  = 2;

    // opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUOTE = 1'b1;

    // event kinds
    localparam logic [KIND_W-1:0] EV_ON     = 2'd0;
    localparam logic [KIND_W-1:0] EV_OFF    = 2'd1;
    localparam logic [KIND_W-1:0] EV_REJECT = 2'd2;

    // table read address select
    localparam logic [2:0] RD_MID  = 3'd0;
    localparam logic [2:0] RD_LO   = 3'd1;
    localparam logic [2:0] RD_LOM1 = 3'd2;
    localparam logic [2:0] RD_UP   = 3'd3;
    localparam logic [2:0] RD_MD   = 3'd4;
    localparam logic [2:0] RD_LW   = 3'd5;
    localparam logic [2:0] RD_SHM1 = 3'd6;

    // read data capture target
    localparam logic [3:0] CAP_NONE = 4'd0;
    localparam logic [3:0] CAP_SU   = 4'd1;
    localparam logic [3:0] CAP_SL   = 4'd2;
    localparam logic [3:0] CAP_NU   = 4'd3;
    localparam logic [3:0] CAP_NM   = 4'd4;
    localparam logic [3:0] CAP_NL   = 4'd5;
    localparam logic [3:0] CAP_OU   = 4'd6;
    localparam logic [3:0] CAP_OM   = 4'd7;
    localparam logic [3:0] CAP_OL   = 4'd8;

    // result strike source, window members in upper, middle, lower order
    localparam logic [2:0] SEL_NU    = 3'd0;
    localparam logic [2:0] SEL_NM    = 3'd1;
    localparam logic [2:0] SEL_NL    = 3'd2;
    localparam logic [2:0] SEL_OU    = 3'd3;
    localparam logic [2:0] SEL_OM    = 3'd4;
    localparam logic [2:0] SEL_OL    = 3'd5;
    localparam logic [2:0] SEL_PRICE = 3'd6;

    typedef struct packed {
        logic              latch_in;
        logic              srch_init;
        logic              srch_step;
        logic              rd_en;
        logic [2:0]        rd_sel;
        logic [3:0]        cap_sel;
        logic              sh_init;
        logic              shift_wr;
        logic              ins_wr;
        logic              win_clear;
        logic              win_set_hi;
        logic              win_set_lo;
        logic              band_load;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
        logic [2:0]        out_sel;
        logic              out_last;
    } cmd_t;

    typedef struct packed {
        logic lo_lt_hi;
        logic rd_eq_price;
        logic lo_lt_count;
        logic lo_is_zero;
        logic full;
        logic sh_gt_lo;
        logic band_out;
        logic mid_ge;
        logic upper_ok;
        logic lower_ok;
        logic active;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/aswt_dp.sv =====
module aswt_dp #(
    parameter int TABLE_DEPTH = aswt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int PRICE_BITS  = aswt_pkg::DEFAULT_PRICE_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [aswt_pkg::PRICE_W-1:0] s_tdata,
    input  aswt_pkg::cmd_t              cmd,
    output aswt_pkg::status_t           status,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [aswt_pkg::PRICE_W-1:0] m_tdata,
    output logic [aswt_pkg::KIND_W-1:0] m_tuser,
    output logic                        m_tlast
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int BW = PRICE_BITS + 2;
    localparam int FW = aswt_pkg::PRICE_W;

    logic [PRICE_BITS-1:0] mem [TABLE_DEPTH];

    logic [PRICE_BITS-1:0] price_reg;
    logic [PRICE_BITS-1:0] rd_data_reg;
    logic [PRICE_BITS-1:0] su_reg, sl_reg;
    logic [PRICE_BITS-1:0] nu_reg, nm_reg, nl_reg;
    logic [PRICE_BITS-1:0] ou_reg, om_reg, ol_reg;
    logic [CW-1:0]         count_reg, lo_reg, hi_reg, sh_reg;
    logic [IW-1:0]         up_reg, md_reg, lw_reg;
    logic                  active_reg;
    logic [BW-1:0]         ubnd_reg, lbnd_reg;
    logic                  m_tvalid_reg;
    logic [FW-1:0]         m_tdata_reg;
    logic [aswt_pkg::KIND_W-1:0] m_tuser_reg;
    logic                  m_tlast_reg;

    logic [PRICE_BITS+FW-1:0] in_ext;
    logic [PRICE_BITS+FW-1:0] out_ext;
    logic [CW:0]              lohi_sum;
    logic [CW-1:0]            mid;
    logic [CW-1:0]            lo_m1, lo_m2, lo_p1, sh_m1;
    logic [CW:0]              lo_p1_wide;
    logic [IW-1:0]            rd_addr;
    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic [PRICE_BITS-1:0]    wr_data;
    logic [BW-1:0]            p4, ubnd_next, lbnd_next;
    logic [PRICE_BITS:0]      p2, pair_sum;
    logic [PRICE_BITS-1:0]    out_val;
    logic                     out_free;

    assign in_ext     = {{PRICE_BITS{1'b0}}, s_tdata};
    assign lohi_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = lohi_sum[CW:1];
    assign lo_m1      = lo_reg - 1'b1;
    assign lo_m2      = lo_reg - CW'(2);
    assign lo_p1      = lo_reg + 1'b1;
    assign lo_p1_wide = {1'b0, lo_reg} + 1'b1;
    assign sh_m1      = sh_reg - 1'b1;
    assign p4         = {price_reg, 2'b00};
    assign p2         = {price_reg, 1'b0};
    assign pair_sum   = {1'b0, su_reg} + {1'b0, sl_reg};
    assign ubnd_next  = {2'b00, nu_reg} + {1'b0, nu_reg, 1'b0} + {2'b00, nm_reg};
    assign lbnd_next  = {2'b00, rd_data_reg} + {1'b0, rd_data_reg, 1'b0} + {2'b00, nm_reg};
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        unique case (cmd.rd_sel)
            aswt_pkg::RD_MID:  rd_addr = mid[IW-1:0];
            aswt_pkg::RD_LO:   rd_addr = lo_reg[IW-1:0];
            aswt_pkg::RD_LOM1: rd_addr = lo_m1[IW-1:0];
            aswt_pkg::RD_UP:   rd_addr = up_reg;
            aswt_pkg::RD_MD:   rd_addr = md_reg;
            aswt_pkg::RD_LW:   rd_addr = lw_reg;
            aswt_pkg::RD_SHM1: rd_addr = sh_m1[IW-1:0];
            default:           rd_addr = mid[IW-1:0];
        endcase
    end

    always_comb begin
        wr_en   = cmd.shift_wr || cmd.ins_wr;
        wr_addr = cmd.shift_wr ? sh_reg[IW-1:0] : lo_reg[IW-1:0];
        wr_data = cmd.shift_wr ? rd_data_reg : price_reg;
    end

    // strike table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            price_reg <= in_ext[PRICE_BITS-1:0];
        end
        if (cmd.cap_sel == aswt_pkg::CAP_SU) su_reg <= rd_data_reg;
        if (cmd.cap_sel == aswt_pkg::CAP_SL) sl_reg <= rd_data_reg;
        if (cmd.cap_sel == aswt_pkg::CAP_NU) nu_reg <= rd_data_reg;
        if (cmd.cap_sel == aswt_pkg::CAP_NM) nm_reg <= rd_data_reg;
        if (cmd.cap_sel == aswt_pkg::CAP_NL) nl_reg <= rd_data_reg;
        if (cmd.cap_sel == aswt_pkg::CAP_OU) ou_reg <= rd_data_reg;
        if (cmd.cap_sel == aswt_pkg::CAP_OM) om_reg <= rd_data_reg;
        if (cmd.cap_sel == aswt_pkg::CAP_OL) ol_reg <= rd_data_reg;
    end

    // search bounds, shift pointer, count, window and trigger bands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            sh_reg     <= '0;
            active_reg <= 1'b0;
            up_reg     <= '0;
            md_reg     <= '0;
            lw_reg     <= '0;
            ubnd_reg   <= '0;
            lbnd_reg   <= '0;
        end else begin
            if (cmd.srch_init) begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end else if (cmd.srch_step) begin
                if (rd_data_reg < price_reg) begin
                    lo_reg <= mid + 1'b1;
                end else begin
                    hi_reg <= mid;
                end
            end
            if (cmd.sh_init) begin
                sh_reg <= count_reg;
            end else if (cmd.shift_wr) begin
                sh_reg <= sh_m1;
            end
            if (cmd.ins_wr) begin
                count_reg <= count_reg + 1'b1;
                if (active_reg) begin
                    if (CW'(up_reg) >= lo_reg) up_reg <= up_reg + 1'b1;
                    if (CW'(md_reg) >= lo_reg) md_reg <= md_reg + 1'b1;
                    if (CW'(lw_reg) >= lo_reg) lw_reg <= lw_reg + 1'b1;
                end
            end
            if (cmd.win_clear) begin
                active_reg <= 1'b0;
            end else if (cmd.win_set_hi) begin
                active_reg <= 1'b1;
                up_reg     <= lo_p1[IW-1:0];
                md_reg     <= lo_reg[IW-1:0];
                lw_reg     <= lo_m1[IW-1:0];
            end else if (cmd.win_set_lo) begin
                active_reg <= 1'b1;
                up_reg     <= lo_reg[IW-1:0];
                md_reg     <= lo_m1[IW-1:0];
                lw_reg     <= lo_m2[IW-1:0];
            end
            if (cmd.band_load) begin
                ubnd_reg <= ubnd_next;
                lbnd_reg <= lbnd_next;
            end
        end
    end

    always_comb begin
        unique case (cmd.out_sel)
            aswt_pkg::SEL_NU:    out_val = nu_reg;
            aswt_pkg::SEL_NM:    out_val = nm_reg;
            aswt_pkg::SEL_NL:    out_val = nl_reg;
            aswt_pkg::SEL_OU:    out_val = ou_reg;
            aswt_pkg::SEL_OM:    out_val = om_reg;
            aswt_pkg::SEL_OL:    out_val = ol_reg;
            aswt_pkg::SEL_PRICE: out_val = price_reg;
            default:             out_val = price_reg;
        endcase
    end

    assign out_ext = {{FW{1'b0}}, out_val};

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= out_ext[FW-1:0];
            m_tuser_reg <= cmd.out_kind;
            m_tlast_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        status.lo_lt_hi    = lo_reg < hi_reg;
        status.rd_eq_price = rd_data_reg == price_reg;
        status.lo_lt_count = lo_reg < count_reg;
        status.lo_is_zero  = lo_reg == '0;
        status.full        = count_reg == CW'(TABLE_DEPTH);
        status.sh_gt_lo    = sh_reg > lo_reg;
        status.band_out    = (p4 > ubnd_reg) || (p4 < lbnd_reg);
        status.mid_ge      = p2 >= pair_sum;
        status.upper_ok    = lo_p1_wide < {1'b0, count_reg};
        status.lower_ok    = lo_reg > CW'(1);
        status.active      = active_reg;
        status.out_free    = out_free;
    end

endmodule

// ===== rtl/aswt_ctrl.sv =====
module aswt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  aswt_pkg::status_t status,
    output aswt_pkg::cmd_t    cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_BAND     = 5'd1;
    localparam logic [4:0] S_OLD_M    = 5'd2;
    localparam logic [4:0] S_OLD_L    = 5'd3;
    localparam logic [4:0] S_OLD_C    = 5'd4;
    localparam logic [4:0] S_SRCH     = 5'd5;
    localparam logic [4:0] S_SRCH_CMP = 5'd6;
    localparam logic [4:0] S_ADD_CHK  = 5'd7;
    localparam logic [4:0] S_ADD_DUP  = 5'd8;
    localparam logic [4:0] S_ADD_FULL = 5'd9;
    localparam logic [4:0] S_REJECT   = 5'd10;
    localparam logic [4:0] S_SHIFT    = 5'd11;
    localparam logic [4:0] S_SHIFT_WR = 5'd12;
    localparam logic [4:0] S_Q_CHK    = 5'd13;
    localparam logic [4:0] S_Q_RDL    = 5'd14;
    localparam logic [4:0] S_Q_CAPL   = 5'd15;
    localparam logic [4:0] S_Q_SEL    = 5'd16;
    localparam logic [4:0] S_Q_NU     = 5'd17;
    localparam logic [4:0] S_Q_NM     = 5'd18;
    localparam logic [4:0] S_Q_NL     = 5'd19;
    localparam logic [4:0] S_Q_BAND   = 5'd20;
    localparam logic [4:0] S_EMIT_ON  = 5'd21;
    localparam logic [4:0] S_EMIT_OFF = 5'd22;

    logic [4:0] state_reg, state_next;
    logic       op_reg, op_next;
    logic       requote_reg, requote_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [4:0] no_window_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= aswt_pkg::OP_ADD;
            requote_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            requote_reg <= requote_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign s_tready        = state_reg == S_IDLE;
    assign no_window_state = requote_reg ? S_EMIT_OFF : S_IDLE;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        requote_next = requote_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    op_next      = s_tuser;
                    requote_next = 1'b0;
                    if (s_tuser != aswt_pkg::OP_ADD && status.active) begin
                        state_next = S_BAND;
                    end else begin
                        cmd.srch_init = 1'b1;
                        state_next    = S_SRCH;
                    end
                end
            end
            S_BAND: begin
                if (status.band_out) begin
                    requote_next = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = aswt_pkg::RD_UP;
                    state_next   = S_OLD_M;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OLD_M: begin
                cmd.cap_sel = aswt_pkg::CAP_OU;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = aswt_pkg::RD_MD;
                state_next  = S_OLD_L;
            end
            S_OLD_L: begin
                cmd.cap_sel = aswt_pkg::CAP_OM;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = aswt_pkg::RD_LW;
                state_next  = S_OLD_C;
            end
            S_OLD_C: begin
                cmd.cap_sel   = aswt_pkg::CAP_OL;
                cmd.srch_init = 1'b1;
                state_next    = S_SRCH;
            end
            S_SRCH: begin
                if (status.lo_lt_hi) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = aswt_pkg::RD_MID;
                    state_next = S_SRCH_CMP;
                end else begin
                    state_next = (op_reg == aswt_pkg::OP_ADD) ? S_ADD_CHK : S_Q_CHK;
                end
            end
            S_SRCH_CMP: begin
                cmd.srch_step = 1'b1;
                state_next    = S_SRCH;
            end
            S_ADD_CHK: begin
                if (status.lo_lt_count) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = aswt_pkg::RD_LO;
                    state_next = S_ADD_DUP;
                end else begin
                    state_next = S_ADD_FULL;
                end
            end
            S_ADD_DUP: begin
                state_next = status.rd_eq_price ? S_IDLE : S_ADD_FULL;
            end
            S_ADD_FULL: begin
                if (status.full) begin
                    state_next = S_REJECT;
                end else begin
                    cmd.sh_init = 1'b1;
                    state_next  = S_SHIFT;
                end
            end
            S_REJECT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = aswt_pkg::EV_REJECT;
                    cmd.out_sel  = aswt_pkg::SEL_PRICE;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (status.sh_gt_lo) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = aswt_pkg::RD_SHM1;
                    state_next = S_SHIFT_WR;
                end else begin
                    cmd.ins_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT;
            end
            S_Q_CHK: begin
                cnt_next = '0;
                if (status.lo_lt_count && !status.lo_is_zero) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = aswt_pkg::RD_LO;
                    state_next = S_Q_RDL;
                end else begin
                    cmd.win_clear = 1'b1;
                    state_next    = no_window_state;
                end
            end
            S_Q_RDL: begin
                cmd.cap_sel = aswt_pkg::CAP_SU;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = aswt_pkg::RD_LOM1;
                state_next  = S_Q_CAPL;
            end
            S_Q_CAPL: begin
                cmd.cap_sel = aswt_pkg::CAP_SL;
                state_next  = S_Q_SEL;
            end
            S_Q_SEL: begin
                priority if (status.mid_ge && status.upper_ok) begin
                    cmd.win_set_hi = 1'b1;
                    state_next     = S_Q_NU;
                end else if (!status.mid_ge && status.lower_ok) begin
                    cmd.win_set_lo = 1'b1;
                    state_next     = S_Q_NU;
                end else begin
                    cmd.win_clear = 1'b1;
                    state_next    = no_window_state;
                end
            end
            S_Q_NU: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = aswt_pkg::RD_UP;
                state_next = S_Q_NM;
            end
            S_Q_NM: begin
                cmd.cap_sel = aswt_pkg::CAP_NU;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = aswt_pkg::RD_MD;
                state_next  = S_Q_NL;
            end
            S_Q_NL: begin
                cmd.cap_sel = aswt_pkg::CAP_NM;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = aswt_pkg::RD_LW;
                state_next  = S_Q_BAND;
            end
            S_Q_BAND: begin
                cmd.cap_sel   = aswt_pkg::CAP_NL;
                cmd.band_load = 1'b1;
                state_next    = S_EMIT_ON;
            end
            S_EMIT_ON: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = aswt_pkg::EV_ON;
                    cmd.out_sel  = aswt_pkg::SEL_NU + {1'b0, cnt_reg};
                    cmd.out_last = (cnt_reg == 2'd2) && !requote_reg;
                    if (cnt_reg == 2'd2) begin
                        cnt_next   = '0;
                        state_next = no_window_state;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_EMIT_OFF: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = aswt_pkg::EV_OFF;
                    cmd.out_sel  = aswt_pkg::SEL_OU + {1'b0, cnt_reg};
                    cmd.out_last = cnt_reg == 2'd2;
                    if (cnt_reg == 2'd2) begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/atm_strike_window_tracker.sv =====
// Strike window tracker.
// Input stream (s_): one transfer per item; s_tuser is the opcode (0 add
// strike, 1 quote midpoint), s_tdata the price in 1/10000 units.
// Result stream (m_): watch-on, watch-off and reject events; m_tuser is the
// event kind, m_tdata the strike price, m_tlast marks the last event of an item.
// One item at a time. A lookup is a binary search over the strike table,
// each probe a registered table read, then a compare. An add then moves
// every strike above its place up by one entry, reading and writing each
// entry in turn. A quote that chooses a window reads its three strikes and
// loads the trigger bands before its events; when it replaces a watched
// window it first reads the old window's strikes and emits their watch-off
// events after the watch-on events. A quote inside the trigger bands emits
// nothing.
// Results leave through a single output register; while the receiver stalls
// the block holds at the next event, and it takes the next item as soon as
// its last event sits in that register.
// Reset empties the table and drops the watched window; table contents are
// not cleared, only the count, so no clearing pass is needed.

`include "assert_macros.svh"

module atm_strike_window_tracker #(
    parameter int TABLE_DEPTH = aswt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int PRICE_BITS  = aswt_pkg::DEFAULT_PRICE_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [aswt_pkg::PRICE_W-1:0] s_tdata,   // price
    input  logic                         s_tuser,   // opcode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [aswt_pkg::PRICE_W-1:0] m_tdata,   // strike_price
    output logic [aswt_pkg::KIND_W-1:0]  m_tuser,   // event_kind
    output logic                         m_tlast    // last_event
);

    aswt_pkg::cmd_t    cmd;
    aswt_pkg::status_t status;

    aswt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    aswt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PRICE_BITS  (PRICE_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a result is only loaded when the output register can take it
    `ASSERT_IMPLY(a_load_free, aclk, aresetn, cmd.out_load, status.out_free, "load over pending")
    // an accepted item always keeps the block busy in the cycle after it is taken
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "back to back")
    // a reject is always the only result of its item
    `ASSERT_IMPLY(a_reject_last, aclk, aresetn, m_tvalid && (m_tuser == aswt_pkg::EV_REJECT), m_tlast, "no last")

endmodule
